// File: design/ist_pkg.sv
// Shared types and constants for the integer set table.
`timescale 1ns / 1ps

package ist_pkg;

    // Default store depth
    localparam int unsigned CAPACITY_DEF = 64;

    // Field widths fixed by the interface
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 7;

    // Request modes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_GET    = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Request beat
    typedef struct packed {
        logic [1:0]                mode;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } ist_req_t;

    // Result beat
    typedef struct packed {
        logic [1:0]                status;
        logic [POS_W-1:0]          found_position;
        logic signed [VALUE_W-1:0] read_value;
        logic [POS_W-1:0]          count;
    } ist_rsp_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic lookup;    // capture the hit flag for a new request
        logic get_mode;  // match on slot index rather than on value
        logic remove;    // shift down from the hit slot onwards
        logic add;       // write the key into the first free slot
    } ist_cell_ctrl_t;

endpackage

// File: design/ist_cell.sv
// One slot of the set store: entry register, match flag and shift link.
`timescale 1ns / 1ps

module ist_cell #(
    parameter int unsigned CNT_W = 7
) (
    input  logic                                 clk,
    input  ist_pkg::ist_cell_ctrl_t              ctrl,
    input  logic [CNT_W-1:0]                     slot,
    input  logic [CNT_W-1:0]                     count,
    input  logic [CNT_W-1:0]                     target,
    input  logic signed [ist_pkg::VALUE_W-1:0]   lookup_key,
    input  logic signed [ist_pkg::VALUE_W-1:0]   write_key,
    input  logic signed [ist_pkg::VALUE_W-1:0]   neighbour_entry,
    input  logic                                 shift_in,
    output logic                                 shift_out,
    output logic                                 hit,
    output logic signed [ist_pkg::VALUE_W-1:0]   entry
);

    logic signed [ist_pkg::VALUE_W-1:0] entry_reg;
    logic signed [ist_pkg::VALUE_W-1:0] entry_next;
    logic                               hit_reg;
    logic                               hit_next;
    logic                               occupied;

    // Slot holds a member when it lies below the count
    assign occupied = (slot < count);

    // Match on the index for get, on the value otherwise
    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.lookup)
        begin
            if (ctrl.get_mode)
                hit_next = occupied && (slot == target);
            else
                hit_next = occupied && (entry_reg == lookup_key);
        end
    end

    // Pass the shift token down the row once the hit slot is reached
    assign shift_out = shift_in | hit_reg;

    // Take the neighbour's entry on remove, the key on add, else hold
    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.remove && shift_out)
            entry_next = neighbour_entry;
        else if (ctrl.add && (slot == count))
            entry_next = write_key;
        else
            entry_next = entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign hit   = hit_reg;
    assign entry = entry_reg;

endmodule

// File: design/integer_set_table.sv
// Top level of the integer set table: request/result channels and cell row.
//
// Keeps a set of distinct 32-bit signed integers packed at the front of a
// row of CAPACITY cells, with a count of members.
// Request channel (req_valid/req_ready/req): mode add, remove, query or get,
// a value and a 1-based position. Result channel (rsp_valid/rsp_ready/rsp):
// status, found position, read value and the count after the request.
// For each request, in the accept cycle every cell compares its
// entry (or its index, for get) against the request and registers a hit
// flag; in the commit state the hits are combined, the row shifts down or
// takes the new entry, and the result beat is loaded into the output
// register. One request is in flight at a time, so a new request is not
// taken until the compare-then-commit pass over the row is done.
// A new request is taken while a finished result still waits in the output
// register; when the receiver stalls with a result held, the next request
// waits in its commit cycle until the output register frees.
// Reset empties the set (count zero) and drops any pending result.
`timescale 1ns / 1ps

module integer_set_table #(
    parameter int unsigned CAPACITY = ist_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ist_pkg::ist_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ist_pkg::ist_rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (CNT_W > ist_pkg::POS_W) ? CNT_W : ist_pkg::POS_W;

    typedef enum logic {
        S_IDLE,
        S_COMMIT
    } state_t;

    state_t                              state_reg;
    logic [CNT_W-1:0]                    count_reg;
    ist_pkg::ist_req_t                   req_reg;
    logic                                get_ok_reg;
    logic                                rsp_valid_reg;
    ist_pkg::ist_rsp_t                   rsp_reg;

    logic                                accept;
    logic                                commit;
    logic                                get_ok;
    logic [CMP_W-1:0]                    pos_ext;
    logic [CNT_W-1:0]                    get_target;
    ist_pkg::ist_cell_ctrl_t             cell_ctrl;

    logic [CAPACITY-1:0]                 hit_vec;
    logic signed [ist_pkg::VALUE_W-1:0]  entry_arr [CAPACITY];
    logic [CAPACITY:0]                   shift_chain;

    logic                                found;
    logic [CNT_W-1:0]                    found_idx;
    logic signed [ist_pkg::VALUE_W-1:0]  hit_entry;
    logic                                full;
    logic                                do_add;
    logic                                do_remove;
    logic [CNT_W-1:0]                    count_next;
    logic [CNT_W-1:0]                    found_pos_w;
    ist_pkg::ist_rsp_t                   rsp_next;

    // Handshake
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign commit    = (state_reg == S_COMMIT) && (!rsp_valid_reg || rsp_ready);

    // Validate a get position against the count
    assign pos_ext    = CMP_W'(req.position);
    assign get_ok     = (pos_ext != '0) && (pos_ext <= CMP_W'(count_reg));
    assign get_target = CNT_W'(pos_ext - CMP_W'(1));

    // Combine the registered hits; at most one slot matches
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        hit_entry = '0;
        for (int unsigned i = 0; i < CAPACITY; i++)
        begin
            found     = found | hit_vec[i];
            found_idx = found_idx | (hit_vec[i] ? CNT_W'(i) : '0);
            hit_entry = hit_entry | (hit_vec[i] ? entry_arr[i] : '0);
        end
    end

    assign full      = (count_reg >= CNT_W'(CAPACITY));
    assign do_add    = commit && (req_reg.mode == ist_pkg::MODE_ADD) && !found && !full;
    assign do_remove = commit && (req_reg.mode == ist_pkg::MODE_REMOVE) && found;

    // Broadcast control to the row
    always_comb
    begin
        cell_ctrl.lookup   = accept;
        cell_ctrl.get_mode = (req.mode == ist_pkg::MODE_GET);
        cell_ctrl.remove   = do_remove;
        cell_ctrl.add      = do_add;
    end

    // Count after this request
    always_comb
    begin
        count_next = count_reg;
        priority if (do_add)
            count_next = count_reg + CNT_W'(1);
        else if (do_remove)
            count_next = count_reg - CNT_W'(1);
        else
            count_next = count_reg;
    end

    assign found_pos_w = found_idx + CNT_W'(1);

    // Build the result beat
    always_comb
    begin
        rsp_next.status         = ist_pkg::ST_OK;
        rsp_next.found_position = '0;
        rsp_next.read_value     = '0;
        rsp_next.count          = ist_pkg::POS_W'(CMP_W'(count_next));
        unique case (req_reg.mode)
            ist_pkg::MODE_ADD:
            begin
                priority if (found)
                    rsp_next.status = ist_pkg::ST_PRESENT;
                else if (full)
                    rsp_next.status = ist_pkg::ST_FULL;
                else
                    rsp_next.status = ist_pkg::ST_OK;
            end
            ist_pkg::MODE_REMOVE, ist_pkg::MODE_QUERY:
            begin
                if (found)
                    rsp_next.found_position = ist_pkg::POS_W'(CMP_W'(found_pos_w));
                else
                    rsp_next.status = ist_pkg::ST_ABSENT;
            end
            ist_pkg::MODE_GET:
            begin
                if (get_ok_reg)
                    rsp_next.read_value = hit_entry;
                else
                    rsp_next.status = ist_pkg::ST_ABSENT;
            end
            default:
            begin
                rsp_next.status = ist_pkg::ST_ABSENT;
            end
        endcase
    end

    // Row of cells with the shift token running from slot 0 upwards
    assign shift_chain[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [ist_pkg::VALUE_W-1:0] neighbour;

        if (g < CAPACITY - 1)
        begin : g_mid
            assign neighbour = entry_arr[g+1];
        end
        else
        begin : g_last
            assign neighbour = '0;
        end

        ist_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .clk             (clk),
            .ctrl            (cell_ctrl),
            .slot            (CNT_W'(g)),
            .count           (count_reg),
            .target          (get_target),
            .lookup_key      (req.value),
            .write_key       (req_reg.value),
            .neighbour_entry (neighbour),
            .shift_in        (shift_chain[g]),
            .shift_out       (shift_chain[g+1]),
            .hit             (hit_vec[g]),
            .entry           (entry_arr[g])
        );
    end

    // Sequencer, count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            req_reg       <= '0;
            get_ok_reg    <= 1'b0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid on a commit, drop it once the beat is taken
            if (commit)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg    <= req;
                        get_ok_reg <= get_ok;
                        state_reg  <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    if (commit)
                    begin
                        count_reg <= count_next;
                        rsp_reg   <= rsp_next;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // Members are distinct, so at most one slot may match
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> $onehot0(hit_vec))
        else $error("more than one cell matched");

    // The count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    // A new result appears only out of a commit cycle
    a_rsp_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_COMMIT))
        else $error("result raised without a commit");

    // The count changes only on a commit
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(commit))
        else $error("count changed outside a commit");
`endif

endmodule
